// ----- rtl/crq_pkg.sv -----
// Shared types and constants of the command ring queue with repeat.
`timescale 1ns / 1ps

package crq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int CMDQ_DEPTH = 2;

  localparam int CODE_W = 8;
  localparam int ARG_W = 32;
  localparam int REPS_W = 16;
  localparam int ACTION_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_GET = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET_REPEAT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CANCEL_REPEAT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DISABLE_PREV = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_ENABLE_PREV = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_CODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NULL_CODE = 2'd1;

  localparam logic [CODE_W-1:0] RESET_REPEAT_CODE = 8'hFF;
  localparam logic [CODE_W-1:0] RESET_NULL_CODE = 8'h00;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_REFUSED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_REPEAT,
    OP_GET,
    OP_SET,
    OP_CANCEL,
    OP_DISABLE,
    OP_ENABLE,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ARG_W-1:0]  arg;
    logic [REPS_W-1:0] reps;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    op_kind_t kind;
    entry_t   ent;
  } op_t;

  typedef struct packed {
    status_t           status;
    entry_t            got;
    logic [REPS_W-1:0] cur_reps;
    logic              repeating;
  } rsp_t;

endpackage

// ----- rtl/crq_in_if.sv -----
// Command channel: valid/ready handshake carrying one command word.
`timescale 1ns / 1ps

interface crq_in_if;
  logic                           valid;
  logic                           ready;
  logic [crq_pkg::ACTION_W-1:0]   action;
  logic [crq_pkg::CODE_W-1:0]     in_code;
  logic [crq_pkg::ARG_W-1:0]      in_arg;
  logic [crq_pkg::REPS_W-1:0]     in_repeats;

  modport source (output valid, output action, output in_code, output in_arg,
                  output in_repeats, input ready);
  modport sink (input valid, input action, input in_code, input in_arg,
                input in_repeats, output ready);
endinterface

// ----- rtl/crq_out_if.sv -----
// Response channel: valid/ready handshake carrying one response word.
`timescale 1ns / 1ps

interface crq_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [crq_pkg::CODE_W-1:0]   out_code;
  logic [crq_pkg::ARG_W-1:0]    out_arg;
  logic [crq_pkg::REPS_W-1:0]   out_repeats;
  logic [crq_pkg::REPS_W-1:0]   current_repeats;
  logic                         repeating_now;

  modport source (output valid, output status, output out_code, output out_arg,
                  output out_repeats, output current_repeats, output repeating_now,
                  input ready);
  modport sink (input valid, input status, input out_code, input out_arg,
                input out_repeats, input current_repeats, input repeating_now,
                output ready);
endinterface

// ----- rtl/crq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module crq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/crq_front.sv -----
// Front end: accepts command words and classifies them into operations.
`timescale 1ns / 1ps

module crq_front (
  input  logic                        clk,
  input  logic                        rst,
  crq_in_if.sink                      cmd,
  input  logic [crq_pkg::CODE_W-1:0]  repeat_code,
  output logic                        op_valid,
  input  logic                        op_ready,
  output crq_pkg::op_t                op
);

  crq_pkg::op_kind_t kind;

  always_comb begin
    case (cmd.action)
      crq_pkg::ACT_INSERT: begin
        kind = (cmd.in_code == repeat_code) ? crq_pkg::OP_REPEAT : crq_pkg::OP_INSERT;
      end
      crq_pkg::ACT_GET:           kind = crq_pkg::OP_GET;
      crq_pkg::ACT_SET_REPEAT:    kind = crq_pkg::OP_SET;
      crq_pkg::ACT_CANCEL_REPEAT: kind = crq_pkg::OP_CANCEL;
      crq_pkg::ACT_DISABLE_PREV:  kind = crq_pkg::OP_DISABLE;
      crq_pkg::ACT_ENABLE_PREV:   kind = crq_pkg::OP_ENABLE;
      default:                    kind = crq_pkg::OP_NOP;
    endcase
  end

  assign cmd.ready = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        op_valid <= cmd.valid;
      end
      if (cmd.valid && cmd.ready) begin
        op.kind <= kind;
        op.ent.code <= cmd.in_code;
        op.ent.arg <= cmd.in_arg;
        op.ent.reps <= cmd.in_repeats;
      end
    end
  end

endmodule

// ----- rtl/crq_cmdq.sv -----
// Short operation queue between the front end and the execution unit.
`timescale 1ns / 1ps

module crq_cmdq #(
  parameter int DEPTH = crq_pkg::CMDQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  crq_pkg::op_t push_op,
  output logic         pop_valid,
  input  logic         pop_ready,
  output crq_pkg::op_t pop_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crq_pkg::op_t       slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_op;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/crq_back.sv -----
// Execution unit: ring store, pointers, repeat state and the response register.
`timescale 1ns / 1ps

module crq_back #(
  parameter int QUEUE_DEPTH = crq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  crq_pkg::op_t                op,
  input  logic [crq_pkg::CODE_W-1:0]  null_code,
  crq_out_if.source                   rsp
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {S_IDLE, S_READ} state_t;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] i);
    return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] i);
    return (i == '0) ? PTR_W'(QUEUE_DEPTH - 1) : i - 1'b1;
  endfunction

  state_t                   state;
  state_t                   state_next;
  logic [PTR_W-1:0]         head;
  logic [PTR_W-1:0]         head_next;
  logic [PTR_W-1:0]         tail;
  logic [PTR_W-1:0]         tail_next;
  logic                     repeating;
  logic                     repeating_next;
  logic                     allowed;
  logic                     allowed_next;
  crq_pkg::entry_t          last_entry;
  crq_pkg::entry_t          last_next;
  logic [QUEUE_DEPTH-1:0]   slot_valid;
  crq_pkg::op_t             cur_op;
  logic                     rd_valid;
  logic                     rsp_valid;
  crq_pkg::rsp_t            res;
  crq_pkg::rsp_t            res_next;
  logic                     load;
  logic                     out_free;
  logic                     take;
  logic                     full;
  logic                     empty;
  logic                     needs_read;
  logic                     ram_we;
  logic [PTR_W-1:0]         ram_waddr;
  crq_pkg::entry_t          ram_wdata;
  logic                     ram_re;
  logic [PTR_W-1:0]         ram_raddr;
  logic [crq_pkg::ENTRY_W-1:0] ram_rdata;
  crq_pkg::entry_t          rd_entry;

  crq_ram #(
    .WIDTH(crq_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A slot never written since reset reads as an all-zero entry.
  assign rd_entry = rd_valid ? crq_pkg::entry_t'(ram_rdata) : '0;

  assign full = wrap_next(head) == tail;
  assign empty = head == tail;
  assign out_free = !rsp_valid || rsp.ready;
  assign op_ready = (state == S_IDLE) && out_free;
  assign take = op_valid && op_ready;
  assign needs_read = ((op.kind == crq_pkg::OP_REPEAT) && !full && allowed) ||
                      ((op.kind == crq_pkg::OP_GET) && !repeating && !empty);

  assign ram_re = take && needs_read;
  assign ram_raddr = (op.kind == crq_pkg::OP_REPEAT) ? wrap_prev(head) : tail;

  always_comb begin
    state_next = state;
    head_next = head;
    tail_next = tail;
    repeating_next = repeating;
    allowed_next = allowed;
    last_next = last_entry;
    load = 1'b0;
    res_next.status = crq_pkg::ST_OK;
    res_next.got = '0;
    ram_we = 1'b0;
    ram_waddr = head;
    ram_wdata = op.ent;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (needs_read) begin
            state_next = S_READ;
          end else begin
            load = 1'b1;
            case (op.kind)
              crq_pkg::OP_INSERT: begin
                if (full) begin
                  res_next.status = crq_pkg::ST_FULL;
                end else begin
                  ram_we = 1'b1;
                  head_next = wrap_next(head);
                end
              end
              crq_pkg::OP_REPEAT: begin
                res_next.status = full ? crq_pkg::ST_FULL : crq_pkg::ST_REFUSED;
              end
              crq_pkg::OP_GET: begin
                if (repeating) begin
                  res_next.got = last_entry;
                end else begin
                  res_next.status = crq_pkg::ST_EMPTY;
                end
              end
              crq_pkg::OP_SET: begin
                last_next.reps = op.ent.reps;
                repeating_next = op.ent.reps != '0;
                ram_we = 1'b1;
                ram_waddr = wrap_prev(tail);
                ram_wdata = last_next;
              end
              crq_pkg::OP_CANCEL: begin
                last_next.reps = '0;
                repeating_next = 1'b0;
                ram_we = 1'b1;
                ram_waddr = wrap_prev(tail);
                ram_wdata = last_next;
              end
              crq_pkg::OP_DISABLE: allowed_next = 1'b0;
              crq_pkg::OP_ENABLE:  allowed_next = 1'b1;
              default: ;
            endcase
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          load = 1'b1;
          state_next = S_IDLE;
          if (cur_op.kind == crq_pkg::OP_REPEAT) begin
            head_next = wrap_next(head);
            ram_wdata = rd_entry;
            ram_we = rd_entry.code != null_code;
          end else begin
            res_next.got = rd_entry;
            tail_next = wrap_next(tail);
            last_next = rd_entry;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    res_next.cur_reps = last_next.reps;
    res_next.repeating = repeating_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      tail <= '0;
      repeating <= 1'b0;
      allowed <= 1'b0;
      last_entry <= '0;
      slot_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      tail <= tail_next;
      repeating <= repeating_next;
      allowed <= allowed_next;
      last_entry <= last_next;
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid <= slot_valid[ram_raddr];
      end
      if (take) begin
        cur_op <= op;
      end
      if (load) begin
        rsp_valid <= 1'b1;
        res <= res_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.status = res.status;
  assign rsp.out_code = res.got.code;
  assign rsp.out_arg = res.got.arg;
  assign rsp.out_repeats = res.got.reps;
  assign rsp.current_repeats = res.cur_reps;
  assign rsp.repeating_now = res.repeating;

endmodule

// ----- rtl/command_ring_queue_with_repeat_core.sv -----
// Top level of the command ring queue with repeat.
`timescale 1ns / 1ps

// Usage:
// Commands enter on the cmd channel, one word per valid/ready handshake:
// insert, get, set repeat, cancel repeat, and disable or enable repeating
// of the previous command. Every command word yields exactly one response
// word on the rsp channel, in order, with a status, the entry returned by
// a get, and the repeat count and replay flag after the command.
// Two registers, the repeat code and the null code, are to be written by the user
// through the cfg port while no command is in flight; the block does not enforce it.
// A dequeuing get and an accepted repeat insert pass through the read state of
// the execution unit, because the entry store has one registered read port;
// every other command is finished from the idle state, so up to one word per
// cycle while the receiver keeps taking response words.
// A two-word queue sits between the front end and the execution unit. The
// single response register holds a finished word until the receiver takes
// it, so a stalled receiver stops the execution unit, then fills the queue
// and the front register before cmd.ready drops.
// Reset clears the pointers, the flags, the stored entries (through per-slot
// valid bits) and restores the register defaults at the first rising edge
// with rst high.
module command_ring_queue_with_repeat_core #(
  parameter int QUEUE_DEPTH = crq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  crq_in_if.sink                           cmd,
  crq_out_if.source                        rsp,
  input  logic                             cfg_write_en,
  input  logic [crq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [crq_pkg::CODE_W-1:0] repeat_code;
  logic [crq_pkg::CODE_W-1:0] null_code;
  logic                       fe_valid;
  logic                       fe_ready;
  crq_pkg::op_t               fe_op;
  logic                       q_valid;
  logic                       q_ready;
  crq_pkg::op_t               q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_code <= crq_pkg::RESET_REPEAT_CODE;
      null_code <= crq_pkg::RESET_NULL_CODE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        crq_pkg::CFG_REPEAT_CODE: repeat_code <= cfg_data;
        crq_pkg::CFG_NULL_CODE:   null_code <= cfg_data;
        default: ;
      endcase
    end
  end

  crq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .repeat_code(repeat_code),
    .op_valid   (fe_valid),
    .op_ready   (fe_ready),
    .op         (fe_op)
  );

  crq_cmdq #(
    .DEPTH(crq_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fe_valid),
    .push_ready(fe_ready),
    .push_op   (fe_op),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_op    (q_op)
  );

  crq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .op       (q_op),
    .null_code(null_code),
    .rsp      (rsp)
  );

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != crq_pkg::ST_OK) |->
      (rsp.out_code == '0) && (rsp.out_arg == '0) && (rsp.out_repeats == '0))
    else $error("failed command returned entry data");

  a_replay_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.repeating_now |-> rsp.current_repeats != '0)
    else $error("replay flag set with zero repeat count");

  a_empty_not_replay: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == crq_pkg::ST_EMPTY) |-> !rsp.repeating_now)
    else $error("empty status reported while replaying");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the command ring queue with repeat.
`timescale 1ns / 1ps

module tb_top;
  import crq_pkg::*;

  localparam int QDEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int DIR_ROWS = 26;
  localparam int NUM_PHASES = 5;
  localparam int WORDS_PER_PHASE = 96;
  localparam int BURST_LEN = 18;

  localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    entry_t              ent;
  } cmd_word_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [CODE_W-1:0]   code;
    logic [ARG_W-1:0]    arg;
    logic [REPS_W-1:0]   reps;
    logic                fixed;
    status_t             st;
    logic [REPS_W-1:0]   cur;
    logic                rep;
  } dir_row_t;

  typedef enum {GEN_MIX, GEN_FILL, GEN_DRAIN} gen_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  crq_in_if  cmd_ch ();
  crq_out_if rsp_ch ();

  command_ring_queue_with_repeat_core dut (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_ch),
    .rsp          (rsp_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  entry_t            m_store [QDEPTH];
  ptr_t              m_head;
  ptr_t              m_tail;
  logic              m_repeating;
  logic              m_allowed;
  logic [CODE_W-1:0] m_repeat_code;
  logic [CODE_W-1:0] m_null_code;

  rsp_t awaited_rsp [$];
  int   mismatches = 0;
  int   n_checked = 0;
  int   n_sent = 0;
  int   n_full = 0;
  int   n_empty = 0;
  int   n_refused = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ACT_GET,           8'h00, 32'h00000000, 16'h0000, 1'b1, ST_EMPTY,   16'h0000, 1'b0},
    '{ACT_SET_REPEAT,    8'h00, 32'h00000000, 16'h0005, 1'b1, ST_OK,      16'h0005, 1'b1},
    '{ACT_CANCEL_REPEAT, 8'h00, 32'h00000000, 16'h0000, 1'b1, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'hFF, 32'hDEADBEEF, 16'h1234, 1'b1, ST_REFUSED, 16'h0000, 1'b0},
    '{ACT_UNUSED_6,      8'hFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, ST_OK,      16'h0000, 1'b0},
    '{ACT_UNUSED_7,      8'h00, 32'h00000000, 16'h0000, 1'b1, ST_OK,      16'h0000, 1'b0},
    '{ACT_ENABLE_PREV,   8'h00, 32'h00000000, 16'h0000, 1'b1, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'hFF, 32'h12345678, 16'h0042, 1'b1, ST_OK,      16'h0000, 1'b0},
    '{ACT_GET,           8'h00, 32'h00000000, 16'h0000, 1'b1, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'hFE, 32'hFFFFFFFF, 16'hFFFF, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'hFF, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_GET,           8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_GET,           8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_SET_REPEAT,    8'h00, 32'h00000000, 16'h0003, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_GET,           8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'h01, 32'hA5A5A5A5, 16'h0001, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'hFF, 32'h5A5A5A5A, 16'h8000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_GET,           8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_CANCEL_REPEAT, 8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_GET,           8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_SET_REPEAT,    8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_SET_REPEAT,    8'h00, 32'h00000000, 16'hFFFF, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_CANCEL_REPEAT, 8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_DISABLE_PREV,  8'h00, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0},
    '{ACT_INSERT,        8'hFF, 32'h00000000, 16'h0000, 1'b0, ST_OK,      16'h0000, 1'b0}
  };

  function automatic rsp_t apply_command(input cmd_word_t w);
    rsp_t r;
    ptr_t prev_t;
    ptr_t prev_h;
    r = '0;
    r.status = ST_OK;
    prev_t = ptr_t'(m_tail - 1'b1);
    prev_h = ptr_t'(m_head - 1'b1);
    case (w.act)
      ACT_INSERT: begin
        if (ptr_t'(m_head + 1'b1) == m_tail) begin
          r.status = ST_FULL;
        end else if (w.ent.code == m_repeat_code) begin
          if (!m_allowed) begin
            r.status = ST_REFUSED;
          end else begin
            if (m_store[prev_h].code != m_null_code) m_store[m_head] = m_store[prev_h];
            m_head = ptr_t'(m_head + 1'b1);
          end
        end else begin
          m_store[m_head] = w.ent;
          m_head = ptr_t'(m_head + 1'b1);
        end
      end
      ACT_GET: begin
        if (m_repeating) begin
          r.got = m_store[prev_t];
        end else if (m_head != m_tail) begin
          r.got = m_store[m_tail];
          m_tail = ptr_t'(m_tail + 1'b1);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_SET_REPEAT: begin
        m_store[prev_t].reps = w.ent.reps;
        m_repeating = (w.ent.reps != '0);
      end
      ACT_CANCEL_REPEAT: begin
        m_store[prev_t].reps = '0;
        m_repeating = 1'b0;
      end
      ACT_DISABLE_PREV: m_allowed = 1'b0;
      ACT_ENABLE_PREV: m_allowed = 1'b1;
      default: ;
    endcase
    r.cur_reps = m_store[ptr_t'(m_tail - 1'b1)].reps;
    r.repeating = m_repeating;
    return r;
  endfunction

  function automatic cmd_word_t make_command(input gen_kind_t kind, input bit opening);
    cmd_word_t w;
    int unsigned pick;
    w.ent.code = CODE_W'($urandom_range(255));
    w.ent.arg = $urandom;
    w.ent.reps = $urandom_range(1) ? REPS_W'($urandom_range(3)) : REPS_W'($urandom_range(65535));
    pick = $urandom_range(99);
    case (kind)
      GEN_FILL: w.act = opening ? ACT_ENABLE_PREV : ACT_INSERT;
      GEN_DRAIN: w.act = opening ? ACT_CANCEL_REPEAT : ACT_GET;
      default: begin
        if (pick < 40) w.act = ACT_INSERT;
        else if (pick < 68) w.act = ACT_GET;
        else if (pick < 78) w.act = ACT_SET_REPEAT;
        else if (pick < 84) w.act = ACT_CANCEL_REPEAT;
        else if (pick < 88) w.act = ACT_DISABLE_PREV;
        else if (pick < 97) w.act = ACT_ENABLE_PREV;
        else w.act = (pick < 99) ? ACT_UNUSED_6 : ACT_UNUSED_7;
      end
    endcase
    if (w.act == ACT_INSERT) begin
      pick = $urandom_range(99);
      if (pick < 20) w.ent.code = m_repeat_code;
      else if (pick < 30) w.ent.code = m_null_code;
    end
    if (w.act == ACT_SET_REPEAT && $urandom_range(2) == 0) w.ent.reps = '0;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_command(input cmd_word_t w, input bit use_typed, input rsp_t typed);
    rsp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.action = w.act;
    cmd_ch.in_code = w.ent.code;
    cmd_ch.in_arg = w.ent.arg;
    cmd_ch.in_repeats = w.ent.reps;
    do @(posedge clk); while (!cmd_ch.ready);
    r = apply_command(w);
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    if (r.status == ST_REFUSED) n_refused++;
    awaited_rsp.push_back(use_typed ? typed : r);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    cmd_ch.valid = 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write_en = 1'b0;
    if (idx == CFG_REPEAT_CODE) m_repeat_code = val;
    else if (idx == CFG_NULL_CODE) m_null_code = val;
  endtask

  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Response word at %0t with nothing pending", $time);
      end else begin
        want = awaited_rsp.pop_front();
        n_checked++;
        if (rsp_ch.status !== want.status || rsp_ch.out_code !== want.got.code ||
            rsp_ch.out_arg !== want.got.arg || rsp_ch.out_repeats !== want.got.reps ||
            rsp_ch.current_repeats !== want.cur_reps ||
            rsp_ch.repeating_now !== want.repeating) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected st=%0d code=%h arg=%h reps=%h cur=%h rep=%b",
                     $time, want.status, want.got.code, want.got.arg, want.got.reps,
                     want.cur_reps, want.repeating);
            $display("                 actual   st=%0d code=%h arg=%h reps=%h cur=%h rep=%b",
                     rsp_ch.status, rsp_ch.out_code, rsp_ch.out_arg, rsp_ch.out_repeats,
                     rsp_ch.current_repeats, rsp_ch.repeating_now);
          end
        end
      end
    end
  end

  initial begin
    cmd_word_t w;
    rsp_t      typed;
    gen_kind_t burst_kind;
    int        burst_left;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_INSERT;
    cmd_ch.in_code = '0;
    cmd_ch.in_arg = '0;
    cmd_ch.in_repeats = '0;
    rsp_ch.ready = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = CFG_REPEAT_CODE;
    cfg_data = '0;
    foreach (m_store[k]) m_store[k] = '0;
    m_head = '0;
    m_tail = '0;
    m_repeating = 1'b0;
    m_allowed = 1'b0;
    m_repeat_code = RESET_REPEAT_CODE;
    m_null_code = RESET_NULL_CODE;
    burst_left = 0;
    burst_kind = GEN_MIX;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      w.act = dir_tab[i].act;
      w.ent.code = dir_tab[i].code;
      w.ent.arg = dir_tab[i].arg;
      w.ent.reps = dir_tab[i].reps;
      typed = '0;
      typed.status = dir_tab[i].st;
      typed.cur_reps = dir_tab[i].cur;
      typed.repeating = dir_tab[i].rep;
      send_command(w, dir_tab[i].fixed, typed);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_drain();
      case (p)
        0: begin
          write_reg(CFG_REPEAT_CODE, 8'hFF);
          write_reg(CFG_NULL_CODE, 8'h00);
        end
        1: begin
          write_reg(CFG_REPEAT_CODE, 8'h00);
          write_reg(CFG_NULL_CODE, 8'hFF);
        end
        2: write_reg(CFG_NULL_CODE, 8'h00);
        3: begin
          write_reg(CFG_REPEAT_CODE, 8'h80);
          write_reg(CFG_NULL_CODE, 8'h7F);
          write_reg(CFG_SPARE_2, 8'h80);
          write_reg(CFG_SPARE_3, 8'h7F);
        end
        default: begin
          write_reg(CFG_REPEAT_CODE, CFG_DATA_W'($urandom_range(255)));
          write_reg(CFG_NULL_CODE, CFG_DATA_W'($urandom_range(255)));
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (i == WORDS_PER_PHASE / 2) wait_for_drain();
        if (burst_left == 0 && $urandom_range(99) < 5) begin
          burst_kind = $urandom_range(1) ? GEN_FILL : GEN_DRAIN;
          burst_left = BURST_LEN;
        end
        if (burst_left != 0) begin
          w = make_command(burst_kind, burst_left == BURST_LEN);
          burst_left--;
        end else begin
          w = make_command(GEN_MIX, 1'b0);
        end
        send_command(w, 1'b0, '0);
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    mismatches += awaited_rsp.size();
    $display("Sent %0d command words under %0d register settings and four pacing modes.",
             n_sent, NUM_PHASES);
    $display("Checked %0d responses, including %0d full, %0d empty and %0d refused.",
             n_checked, n_full, n_empty, n_refused);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d responses outstanding", awaited_rsp.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
